[design/tpe_pkg.sv]
// shared types, constants and helpers of the trapezoid profile evaluator
`timescale 1ns / 1ps
package tpe_pkg;

  localparam int ADDR_W = 5;
  localparam logic [30:0] MIN_DISTANCE = 31'd29;

  typedef enum logic [2:0] {
    REG_DISTANCE   = 3'd0,
    REG_ACCEL_END  = 3'd1,
    REG_DECEL_START = 3'd2,
    REG_END_TIME   = 3'd3,
    REG_PEAK_ACCEL = 3'd4,
    REG_PEAK_VEL   = 3'd5,
    REG_START_POS  = 3'd6,
    REG_DIRECTION  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_ZERO   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1
  } dir_code_t;

  typedef struct packed {
    logic [30:0]        distance;
    logic [30:0]        accel_end_time;
    logic [30:0]        decel_start_time;
    logic [30:0]        end_time;
    logic [30:0]        peak_accel;
    logic [30:0]        peak_velocity;
    logic signed [31:0] start_position;
    logic [1:0]         direction;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[design/tpe_regs.sv]
// apb register file holding the planned move
`timescale 1ns / 1ps
module tpe_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tpe_pkg::cfg_t               cfg,
  output logic                        wr_stb
);
  import tpe_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_stb = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_stb) begin
      case (idx)
        REG_DISTANCE:    cfg_nxt.distance         = pwdata[30:0];
        REG_ACCEL_END:   cfg_nxt.accel_end_time   = pwdata[30:0];
        REG_DECEL_START: cfg_nxt.decel_start_time = pwdata[30:0];
        REG_END_TIME:    cfg_nxt.end_time         = pwdata[30:0];
        REG_PEAK_ACCEL:  cfg_nxt.peak_accel       = pwdata[30:0];
        REG_PEAK_VEL:    cfg_nxt.peak_velocity    = pwdata[30:0];
        REG_START_POS:   cfg_nxt.start_position   = pwdata;
        REG_DIRECTION:   cfg_nxt.direction        = pwdata[1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DISTANCE:    prdata = {1'b0, cfg_r.distance};
      REG_ACCEL_END:   prdata = {1'b0, cfg_r.accel_end_time};
      REG_DECEL_START: prdata = {1'b0, cfg_r.decel_start_time};
      REG_END_TIME:    prdata = {1'b0, cfg_r.end_time};
      REG_PEAK_ACCEL:  prdata = {1'b0, cfg_r.peak_accel};
      REG_PEAK_VEL:    prdata = {1'b0, cfg_r.peak_velocity};
      REG_START_POS:   prdata = cfg_r.start_position;
      REG_DIRECTION:   prdata = {30'd0, cfg_r.direction};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/tpe_ramp_div.sv]
// sequential divider for the cruise offset v*v/(2*a)
`timescale 1ns / 1ps
module tpe_ramp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [30:0] peak_accel,
  input  logic [30:0] peak_velocity,
  output logic        busy,
  output logic [60:0] ramp
);
  import tpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } div_state_t;

  div_state_t  state_r, state_nxt;
  logic [61:0] nq_r, nq_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [60:0] ramp_r, ramp_nxt;
  logic [31:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, nq_r[61]};
  assign ge     = rem_sh >= {1'b0, peak_accel};
  assign busy   = state_r != S_IDLE;
  assign ramp   = ramp_r;

  always_comb begin
    state_nxt = state_r;
    nq_nxt    = nq_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ramp_nxt  = ramp_r;
    case (state_r)
      S_IDLE: begin
        if (load) state_nxt = S_MUL;
      end
      S_MUL: begin
        nq_nxt    = 62'(peak_velocity) * 62'(peak_velocity);
        rem_nxt   = '0;
        cnt_nxt   = 6'd61;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? 31'(rem_sh - {1'b0, peak_accel}) : rem_sh[30:0];
        nq_nxt  = {nq_r[60:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          ramp_nxt  = (peak_accel == '0) ? '0 : nq_nxt[61:1];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a new write always restarts the offset
    if (load) state_nxt = S_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ramp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ramp_r  <= ramp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

[design/tpe_pipe.sv]
// six-stage datapath evaluating the profile at one time sample
`timescale 1ns / 1ps
module tpe_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [31:0]  sample_time,
  input  tpe_pkg::cfg_t       cfg,
  input  logic [60:0]         ramp,
  output logic                out_valid,
  output logic signed [31:0]  joint_position,
  output logic signed [31:0]  joint_velocity,
  output logic signed [31:0]  joint_accel
);
  import tpe_pkg::*;

  // stage 1: phase select
  logic        v1_r;
  phase_t      ph1_r, ph_in;
  logic [30:0] x1_r, y1_r, z1_r;
  logic [30:0] tt;
  // stage 2: first products
  logic        v2_r;
  phase_t      ph2_r;
  logic [30:0] x2_r;
  logic [61:0] ax2_r, ay2_r, vz2_r;
  // stage 3: second products, velocity
  logic        v3_r;
  phase_t      ph3_r;
  logic [61:0] mhi3_r, mlo3_r;
  logic signed [47:0] vel3_r, vel3_nxt;
  logic [45:0] vz3_r;
  // stage 4: squared term
  logic        v4_r;
  phase_t      ph4_r;
  logic signed [47:0] vel4_r;
  logic [45:0] vz4_r;
  logic [47:0] q4_r;
  logic [92:0] qsum;
  // stage 5: distance magnitude
  logic        v5_r;
  phase_t      ph5_r;
  logic signed [47:0] vel5_r;
  logic signed [63:0] p5_r, p5_nxt;
  // stage 6: sign and saturate
  logic        v6_r;
  logic signed [31:0] pos6_r, vel6_r, acc6_r;
  logic signed [65:0] pos_full, vel_full, acc_full, pmag, vmag, amag;

  assign tt = sample_time[30:0];

  always_comb begin
    if (sample_time[31] || cfg.distance < MIN_DISTANCE) ph_in = PH_ZERO;
    else if (tt <= cfg.accel_end_time) ph_in = PH_ACCEL;
    else if (tt < cfg.decel_start_time) ph_in = PH_CRUISE;
    else if (tt <= cfg.end_time) ph_in = PH_DECEL;
    else ph_in = PH_DONE;
  end

  always_comb begin
    vel3_nxt = '0;
    case (ph2_r)
      PH_ACCEL:  vel3_nxt = $signed({2'b00, ay2_r[61:16]});
      PH_CRUISE: vel3_nxt = $signed({17'd0, cfg.peak_velocity});
      PH_DECEL:  vel3_nxt = $signed({17'd0, cfg.peak_velocity})
                          - $signed({2'b00, ay2_r[61:16]});
      default:   vel3_nxt = '0;
    endcase
  end

  assign qsum = {mhi3_r, 31'd0} + 93'(mlo3_r);

  always_comb begin
    p5_nxt = '0;
    case (ph4_r)
      PH_ACCEL:  p5_nxt = $signed({16'd0, q4_r});
      PH_CRUISE: p5_nxt = $signed({18'd0, vz4_r}) - $signed({3'd0, ramp});
      PH_DECEL:  p5_nxt = $signed({18'd0, vz4_r}) - $signed({16'd0, q4_r});
      PH_DONE:   p5_nxt = $signed({33'd0, cfg.distance});
      default:   p5_nxt = '0;
    endcase
  end

  always_comb begin
    pmag = 66'(p5_r);
    vmag = 66'(vel5_r);
    case (ph5_r)
      PH_ACCEL: amag = $signed({35'd0, cfg.peak_accel});
      PH_DECEL: amag = -$signed({35'd0, cfg.peak_accel});
      default:  amag = '0;
    endcase
    case (cfg.direction)
      DIR_POS: begin
        pos_full = 66'(cfg.start_position) + pmag;
        vel_full = vmag;
        acc_full = amag;
      end
      DIR_NONE: begin
        pos_full = 66'(cfg.start_position);
        vel_full = '0;
        acc_full = '0;
      end
      default: begin
        pos_full = 66'(cfg.start_position) - pmag;
        vel_full = -vmag;
        acc_full = -amag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    ph1_r  <= ph_in;
    x1_r   <= (ph_in == PH_ACCEL) ? tt : 31'(cfg.end_time - tt);
    y1_r   <= (ph_in == PH_ACCEL) ? tt : 31'(tt - cfg.decel_start_time);
    z1_r   <= (ph_in == PH_CRUISE) ? tt : cfg.decel_start_time;

    ph2_r  <= ph1_r;
    x2_r   <= x1_r;
    ax2_r  <= 62'(cfg.peak_accel) * 62'(x1_r);
    ay2_r  <= 62'(cfg.peak_accel) * 62'(y1_r);
    vz2_r  <= 62'(cfg.peak_velocity) * 62'(z1_r);

    ph3_r  <= ph2_r;
    mhi3_r <= 62'(ax2_r[61:31]) * 62'(x2_r);
    mlo3_r <= 62'(ax2_r[30:0]) * 62'(x2_r);
    vel3_r <= vel3_nxt;
    vz3_r  <= vz2_r[61:16];

    ph4_r  <= ph3_r;
    vel4_r <= vel3_r;
    vz4_r  <= vz3_r;
    q4_r   <= (qsum[92:80] != '0) ? 48'h8000_0000_0000 : 48'(qsum[92:33]);

    ph5_r  <= ph4_r;
    vel5_r <= vel4_r;
    p5_r   <= p5_nxt;

    pos6_r <= sat32(pos_full);
    vel6_r <= sat32(vel_full);
    acc6_r <= sat32(acc_full);
  end

  assign out_valid      = v6_r;
  assign joint_position = pos6_r;
  assign joint_velocity = vel6_r;
  assign joint_accel    = acc6_r;

endmodule

[design/trapezoid_profile_eval.sv]
// top level of the trapezoidal motion profile evaluator for one joint
`timescale 1ns / 1ps
// One time sample is taken per clock while busy is low, and its position,
// velocity and acceleration appear at the end of the datapath pipeline for
// one cycle with out_valid; the result cannot be held off. Every
// configuration write restarts the cruise offset divider, which keeps busy
// high through a multiply step and 62 one-bit divide steps; samples are
// refused during that time.
module trapezoid_profile_eval (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          in_sample_time,
  output logic                        out_valid,
  output logic signed [31:0]          out_joint_position,
  output logic signed [31:0]          out_joint_velocity,
  output logic signed [31:0]          out_joint_accel
);
  import tpe_pkg::*;

  cfg_t        cfg;
  logic        wr_stb;
  logic [60:0] ramp;

  tpe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .wr_stb  (wr_stb)
  );

  tpe_ramp_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (wr_stb),
    .peak_accel    (cfg.peak_accel),
    .peak_velocity (cfg.peak_velocity),
    .busy          (busy),
    .ramp          (ramp)
  );

  tpe_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (start & ~busy),
    .sample_time    (in_sample_time),
    .cfg            (cfg),
    .ramp           (ramp),
    .out_valid      (out_valid),
    .joint_position (out_joint_position),
    .joint_velocity (out_joint_velocity),
    .joint_accel    (out_joint_accel)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##6 out_valid)
    else $error("word did not come out after six cycles");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> busy)
    else $error("divider not started by register write");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("word out without a matching accept");

endmodule
